[rtl/direction_to_pitch_yaw_defines.svh]
// Assertion macros shared by the direction-to-angle block.
`ifndef DIRECTION_TO_PITCH_YAW_DEFINES_SVH
`define DIRECTION_TO_PITCH_YAW_DEFINES_SVH
`ifndef ASSERT_OFF
// Plain property, checked at every clock edge outside reset.
`define DTPY_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Antecedent this cycle, consequent in the next one.
`define DTPY_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define DTPY_ASSERT(lbl, clk, rst, prop)
`define DTPY_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/dtpy_pkg.sv]
package dtpy_pkg;

   // Magnitudes after normalization lie in [2^30, 2^31]
   localparam int MAG_BITS   = 32;
   localparam int SHIFT_BITS = 5;
   // CORDIC datapath: x/y signed, angle in degrees with 20 fraction bits
   localparam int CW         = 36;
   localparam int AW         = 28;
   localparam int FULL_BITS  = 29;
   localparam int ANG_BITS   = 17;

   localparam logic [30:0] GAIN_Q30        = 31'd1768195363;
   localparam logic [63:0] DEG_PER_RAD_Q20 = 64'd60078979;

   localparam logic [FULL_BITS-1:0] FULL_Q20 = 29'd377487360;  // 360 deg
   localparam logic [FULL_BITS-1:0] HALF_Q20 = 29'd188743680;  // 180 deg
   localparam logic [FULL_BITS-1:0] QUAD_Q20 = 29'd94371840;   // 90 deg
   localparam logic [AW-1:0]        OCT_Q20  = 28'd47185920;   // 45 deg

   localparam logic [ANG_BITS-1:0] FULL_Q8  = 17'd92160;
   localparam logic [ANG_BITS-1:0] DOWN_Q8  = 17'd69120;       // 270 deg
   localparam logic [ANG_BITS-1:0] UP_Q8    = 17'd23040;       // 90 deg

   typedef struct packed {
      logic                special;   // x and y both zero
      logic                x_neg;
      logic                y_neg;
      logic                z_pos;
      logic [MAG_BITS-1:0] zs;        // gain-scaled |z|
      logic [ANG_BITS-1:0] yaw;
   } side_type;

   typedef struct packed {
      logic                 vld;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [AW-1:0] a;
      side_type             side;
   } cordic_type;

   typedef struct packed {
      logic [ANG_BITS-1:0] pitch;
      logic [ANG_BITS-1:0] yaw;
   } angles_type;

   // Shift-subtract division, elaboration use only
   function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], num[b]};
         if (r >= den) begin
            r    = r - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // atan(2^-stage) in degrees, Q20, from the power series in Q36
   function automatic logic signed [AW-1:0] atan_q20(input int stage);
      logic signed [63:0] sum;
      logic [63:0]        d;
      logic [63:0]        term;
      logic [63:0]        prod;
      int                 e;
      sum = '0;
      if (stage == 0) begin
         return OCT_Q20;
      end
      for (int k = 0; k < 18; k++) begin
         e = 36 - stage * (2 * k + 1);
         d = 64'(2 * k + 1);
         if (e >= 0) begin
            term = div_u64((64'd1 << e) + (d >> 1), d);
            if ((k & 1) != 0) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
      end
      prod = 64'(sum) * DEG_PER_RAD_Q20 + (64'd1 << 35);
      return AW'(prod >> 36);
   endfunction

   // First-quadrant angle clamped to [0, 90] deg
   function automatic logic [FULL_BITS-1:0] clamp_quad(input logic signed [AW-1:0] a);
      logic [FULL_BITS-1:0] v;
      v = {{(FULL_BITS-AW){1'b0}}, a};
      if (a[AW-1]) begin
         return '0;
      end
      if (v > QUAD_Q20) begin
         return QUAD_Q20;
      end
      return v;
   endfunction

   // Round Q20 to Q8, full circle wraps to zero
   function automatic logic [ANG_BITS-1:0] to_q8(input logic [FULL_BITS-1:0] a);
      logic [FULL_BITS-1:0] s;
      logic [ANG_BITS-1:0]  r;
      s = a + FULL_BITS'(2048);
      r = s[FULL_BITS-1:12];
      if (r >= FULL_Q8) begin
         r = r - FULL_Q8;
      end
      return r;
   endfunction

endpackage

[rtl/dtpy_req_if.sv]
interface dtpy_req_if #(parameter int COORD_BITS = 24);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] x_coord;
   logic signed [COORD_BITS-1:0] y_coord;
   logic signed [COORD_BITS-1:0] z_coord;

   modport source (output valid, x_coord, y_coord, z_coord, input ready);
   modport sink (input valid, x_coord, y_coord, z_coord, output ready);
endinterface

[rtl/dtpy_rsp_if.sv]
interface dtpy_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [dtpy_pkg::ANG_BITS-1:0] pitch_angle;
   logic [dtpy_pkg::ANG_BITS-1:0] yaw_angle;

   modport source (output valid, pitch_angle, yaw_angle, input ready);
   modport sink (input valid, pitch_angle, yaw_angle, output ready);
endinterface

[rtl/dtpy_norm.sv]
module dtpy_norm #(
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_vld,
   input  logic signed [COORD_BITS-1:0] x_coord,
   input  logic signed [COORD_BITS-1:0] y_coord,
   input  logic signed [COORD_BITS-1:0] z_coord,
   output dtpy_pkg::cordic_type         cordic_out
);
   localparam int MB = dtpy_pkg::MAG_BITS;
   localparam int SB = dtpy_pkg::SHIFT_BITS;
   localparam int CW = dtpy_pkg::CW;

   typedef struct packed {
      logic          vld;
      logic [MB-1:0] ax;
      logic [MB-1:0] ay;
      logic [MB-1:0] az;
      logic          special;
      logic          x_neg;
      logic          y_neg;
      logic          z_pos;
   } mag_type;

   mag_type              s1_in, s1_ff, s2_ff, s3_in, s3_ff;
   logic [SB-1:0]        sh_in, sh_ff;
   logic [MB-1:0]        mag_or;
   logic signed [MB:0]   xs, ys, zs;
   logic [MB+30:0]       prod;
   logic [MB+30:0]       prod_rnd;
   dtpy_pkg::cordic_type c_in, c_ff;

   // stage 1: sign-extend, magnitudes, flags
   always_comb begin
      xs = {{(MB+1-COORD_BITS){x_coord[COORD_BITS-1]}}, x_coord};
      ys = {{(MB+1-COORD_BITS){y_coord[COORD_BITS-1]}}, y_coord};
      zs = {{(MB+1-COORD_BITS){z_coord[COORD_BITS-1]}}, z_coord};
      s1_in.vld     = in_vld;
      s1_in.ax      = xs[MB] ? MB'(-xs) : MB'(xs);
      s1_in.ay      = ys[MB] ? MB'(-ys) : MB'(ys);
      s1_in.az      = zs[MB] ? MB'(-zs) : MB'(zs);
      s1_in.special = (x_coord == '0) && (y_coord == '0);
      s1_in.x_neg   = xs[MB];
      s1_in.y_neg   = ys[MB];
      s1_in.z_pos   = !zs[MB] && (z_coord != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) s1_ff.vld <= 1'b0;
      else if (en) s1_ff <= s1_in;
   end

   // stage 2: leading-one search on the OR of magnitudes (same msb as the max)
   always_comb begin
      mag_or = s1_ff.ax | s1_ff.ay | s1_ff.az;
      sh_in  = '0;
      for (int i = 0; i < 30; i++) begin
         if (mag_or[i]) sh_in = SB'(30 - i);
      end
      if (mag_or[MB-1] || mag_or[MB-2]) sh_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.vld <= 1'b0;
      end else if (en) begin
         s2_ff <= s1_ff;
         sh_ff <= sh_in;
      end
   end

   // stage 3: common left shift
   always_comb begin
      s3_in    = s2_ff;
      s3_in.ax = s2_ff.ax << sh_ff;
      s3_in.ay = s2_ff.ay << sh_ff;
      s3_in.az = s2_ff.az << sh_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) s3_ff.vld <= 1'b0;
      else if (en) s3_ff <= s3_in;
   end

   // stage 4: scale |z| by the CORDIC gain, launch the first rotation chain
   always_comb begin
      prod               = s3_ff.az * dtpy_pkg::GAIN_Q30;
      prod_rnd           = prod + (63'd1 << 29);
      c_in.vld           = s3_ff.vld;
      c_in.x             = {{(CW-MB){1'b0}}, s3_ff.ax};
      c_in.y             = {{(CW-MB){1'b0}}, s3_ff.ay};
      c_in.a             = '0;
      c_in.side.special  = s3_ff.special;
      c_in.side.x_neg    = s3_ff.x_neg;
      c_in.side.y_neg    = s3_ff.y_neg;
      c_in.side.z_pos    = s3_ff.z_pos;
      c_in.side.zs       = prod_rnd[MB+29:30];
      c_in.side.yaw      = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) c_ff.vld <= 1'b0;
      else if (en) c_ff <= c_in;
   end

   assign cordic_out = c_ff;

endmodule

[rtl/dtpy_cell.sv]
module dtpy_cell #(
   parameter int STAGE = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  dtpy_pkg::cordic_type cin,
   output dtpy_pkg::cordic_type cout
);
   localparam int CW = dtpy_pkg::CW;
   localparam int AW = dtpy_pkg::AW;
   localparam logic signed [AW-1:0] ATAN_STEP = dtpy_pkg::atan_q20(STAGE);

   dtpy_pkg::cordic_type step_in, step_ff;
   logic signed [CW-1:0] dx, dy;

   // one vectoring micro-rotation: drive y toward zero
   always_comb begin
      dx      = cin.y >>> STAGE;
      dy      = cin.x >>> STAGE;
      step_in = cin;
      if (!cin.y[CW-1]) begin
         step_in.x = cin.x + dx;
         step_in.y = cin.y - dy;
         step_in.a = cin.a + ATAN_STEP;
      end else begin
         step_in.x = cin.x - dx;
         step_in.y = cin.y + dy;
         step_in.a = cin.a - ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) step_ff.vld <= 1'b0;
      else if (en) step_ff <= step_in;
   end

   assign cout = step_ff;

endmodule

[rtl/dtpy_skid.sv]
`include "direction_to_pitch_yaw_defines.svh"

module dtpy_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_vld,
   input  dtpy_pkg::angles_type in_data,
   output logic                 in_ready,
   dtpy_rsp_if.source           rsp_chan
);
   logic                 out_vld_ff, skid_vld_ff;
   dtpy_pkg::angles_type out_data_ff, skid_data_ff;
   logic                 out_free;

   assign out_free = !out_vld_ff || rsp_chan.ready;
   assign in_ready = !skid_vld_ff;

   // output register plus one spare entry, so the pipe stalls on a registered flag
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_vld_ff) begin
            out_data_ff <= skid_data_ff;
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_data_ff <= in_data;
            out_vld_ff  <= in_vld;
         end
      end else if (in_vld && !skid_vld_ff) begin
         skid_data_ff <= in_data;
         skid_vld_ff  <= 1'b1;
      end
   end

   assign rsp_chan.valid       = out_vld_ff;
   assign rsp_chan.pitch_angle = out_data_ff.pitch;
   assign rsp_chan.yaw_angle   = out_data_ff.yaw;

   // spare entry only fills behind a held output
   `DTPY_ASSERT(a_skid_behind_out, clock, reset, skid_vld_ff |-> out_vld_ff)
   // a stalled output with a transaction arriving must park it
   `DTPY_ASSERT_NEXT(a_skid_catch, clock, reset, !out_free && !skid_vld_ff && in_vld, skid_vld_ff)

endmodule

[rtl/direction_to_pitch_yaw.sv]
// Req to rsp: norm stages, yaw chain, mid reg, pitch chain, final reg, output register.
// Throughput: one vector per cycle; each rotation stage is its own register cell,
// so the only stall source is the rsp side backing up into the two-entry output buffer.
// Reset (synchronous, active high) clears all stage valid flags and the output buffer;
// data registers are not reset.
`include "direction_to_pitch_yaw_defines.svh"

module direction_to_pitch_yaw #(
   parameter int COORD_BITS    = 24,
   parameter int CORDIC_STAGES = 16
) (
   input  logic       clock,
   input  logic       reset,
   dtpy_req_if.sink   req_chan,
   dtpy_rsp_if.source rsp_chan
);
   localparam int CW = dtpy_pkg::CW;
   localparam int MB = dtpy_pkg::MAG_BITS;
   localparam int FB = dtpy_pkg::FULL_BITS;

   typedef struct packed {
      logic                 vld;
      dtpy_pkg::angles_type data;
   } result_type;

   logic                 pipe_en;
   dtpy_pkg::cordic_type c1 [CORDIC_STAGES+1];
   dtpy_pkg::cordic_type c2 [CORDIC_STAGES+1];
   dtpy_pkg::cordic_type mid_in, mid_ff;
   result_type           fin_in, fin_ff;
   logic [FB-1:0]        theta, yaw_q20, phi, pitch_q20;
   logic                 fin_in_range;

   assign req_chan.ready = pipe_en;

   // magnitudes, normalizing shift, gain-scaled |z|
   dtpy_norm #(.COORD_BITS(COORD_BITS)) u_norm (
      .clock      (clock),
      .reset      (reset),
      .en         (pipe_en),
      .in_vld     (req_chan.valid),
      .x_coord    (req_chan.x_coord),
      .y_coord    (req_chan.y_coord),
      .z_coord    (req_chan.z_coord),
      .cordic_out (c1[0])
   );

   // first chain: atan2(|y|, |x|) and xy magnitude
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_yaw
      dtpy_cell #(.STAGE(i)) u_step (
         .clock (clock),
         .reset (reset),
         .en    (pipe_en),
         .cin   (c1[i]),
         .cout  (c1[i+1])
      );
   end

   // quadrant map for yaw, load magnitude and scaled |z| for the second chain
   always_comb begin
      theta = dtpy_pkg::clamp_quad(c1[CORDIC_STAGES].a);
      if (!c1[CORDIC_STAGES].side.x_neg) begin
         yaw_q20 = c1[CORDIC_STAGES].side.y_neg ? dtpy_pkg::FULL_Q20 - theta : theta;
      end else begin
         yaw_q20 = c1[CORDIC_STAGES].side.y_neg ? dtpy_pkg::HALF_Q20 + theta
                                                : dtpy_pkg::HALF_Q20 - theta;
      end
      mid_in          = c1[CORDIC_STAGES];
      mid_in.y        = {{(CW-MB){1'b0}}, c1[CORDIC_STAGES].side.zs};
      mid_in.a        = '0;
      mid_in.side.yaw = dtpy_pkg::to_q8(yaw_q20);
   end

   always_ff @(posedge clock) begin
      if (reset) mid_ff.vld <= 1'b0;
      else if (pipe_en) mid_ff <= mid_in;
   end

   assign c2[0] = mid_ff;

   // second chain: atan2(|z|, xy magnitude)
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_pitch
      dtpy_cell #(.STAGE(i)) u_step (
         .clock (clock),
         .reset (reset),
         .en    (pipe_en),
         .cin   (c2[i]),
         .cout  (c2[i+1])
      );
   end

   // pitch sign, rounding, and the vertical vector case
   always_comb begin
      phi       = dtpy_pkg::clamp_quad(c2[CORDIC_STAGES].a);
      pitch_q20 = c2[CORDIC_STAGES].side.z_pos ? dtpy_pkg::FULL_Q20 - phi : phi;
      fin_in.vld        = c2[CORDIC_STAGES].vld;
      fin_in.data.pitch = dtpy_pkg::to_q8(pitch_q20);
      fin_in.data.yaw   = c2[CORDIC_STAGES].side.yaw;
      if (c2[CORDIC_STAGES].side.special) begin
         fin_in.data.pitch = c2[CORDIC_STAGES].side.z_pos ? dtpy_pkg::DOWN_Q8
                                                          : dtpy_pkg::UP_Q8;
         fin_in.data.yaw   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) fin_ff.vld <= 1'b0;
      else if (pipe_en) fin_ff <= fin_in;
   end

   dtpy_skid u_skid (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (fin_ff.vld),
      .in_data  (fin_ff.data),
      .in_ready (pipe_en),
      .rsp_chan (rsp_chan)
   );

   assign fin_in_range = (fin_ff.data.pitch < dtpy_pkg::FULL_Q8) &&
                         (fin_ff.data.yaw < dtpy_pkg::FULL_Q8);

   // wrapped angles never reach a full circle
   `DTPY_ASSERT(a_fin_range, clock, reset, fin_ff.vld |-> fin_in_range)
   // xy magnitude out of the first chain must stay positive in the datapath width
   `DTPY_ASSERT(a_mag_positive, clock, reset, mid_ff.vld |-> !mid_ff.x[CW-1])

endmodule
